// ===== rtl/scmc_pkg.sv =====
// Shared types, constants and helper functions for the serial command mode controller.
// Holds the command name table and the candidate mask narrowing used for line matching.
// Depends on nothing; every RTL file of the block imports it.
package scmc_pkg;

    localparam int LINE_CAPACITY_DEF = 32;
    localparam int NUM_CMDS          = 5;
    localparam int NAME_SLOTS        = 8;

    localparam logic [15:0] DEBOUNCE_RESET  = 16'd200;
    localparam logic [11:0] THRESHOLD_RESET = 12'd2048;
    localparam logic [15:0] TICKS_MAX       = 16'hFFFF;

    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    localparam logic [NUM_CMDS-1:0] ALL_CANDIDATES = '1;

    typedef enum logic [1:0] {
        ACT_BYTE   = 2'd0,
        ACT_PRESS  = 2'd1,
        ACT_SAMPLE = 2'd2,
        ACT_TICK   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        MODE_SERIAL = 2'd0,
        MODE_PRESS  = 2'd1,
        MODE_CONV   = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        RSP_NONE    = 4'd0,
        RSP_UART    = 4'd1,
        RSP_BUTTON  = 4'd2,
        RSP_ADC     = 4'd3,
        RSP_LEDON   = 4'd4,
        RSP_LEDOFF  = 4'd5,
        RSP_DENIED  = 4'd6,
        RSP_UNKNOWN = 4'd7,
        RSP_REPORT  = 4'd8
    } t_rsp;

    typedef enum logic [2:0] {
        CMD_UART     = 3'd0,
        CMD_BUTTON   = 3'd1,
        CMD_ADC      = 3'd2,
        CMD_LAMP_ON  = 3'd3,
        CMD_LAMP_OFF = 3'd4,
        CMD_NONE     = 3'd5
    } t_cmd;

    typedef enum logic [7:0] {
        CFG_DEBOUNCE  = 8'd0,
        CFG_THRESHOLD = 8'd1
    } t_cfg_reg;

    typedef logic [7:0] t_name [NAME_SLOTS];

    localparam t_name CMD_NAMES [NUM_CMDS] = '{
        '{8'h55, 8'h41, 8'h52, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h42, 8'h55, 8'h54, 8'h54, 8'h4F, 8'h4E, 8'h00, 8'h00},
        '{8'h41, 8'h44, 8'h43, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h4C, 8'h45, 8'h44, 8'h4F, 8'h4E, 8'h00, 8'h00, 8'h00},
        '{8'h4C, 8'h45, 8'h44, 8'h4F, 8'h46, 8'h46, 8'h00, 8'h00}
    };

    // Positions past the end of the name table read as a zero character.
    function automatic logic [NUM_CMDS-1:0] narrow_mask(
        input logic [NUM_CMDS-1:0] mask,
        input logic                pos_over,
        input logic [2:0]          pos_lo,
        input logic [7:0]          b
    );
        logic [NUM_CMDS-1:0] res;
        logic [7:0]          ch;
        res = mask;
        for (int i = 0; i < NUM_CMDS; i++) begin
            ch = pos_over ? CHAR_NUL : CMD_NAMES[i][pos_lo];
            if (ch != b) begin
                res[i] = 1'b0;
            end
        end
        return res;
    endfunction

    function automatic t_cmd first_hit(input logic [NUM_CMDS-1:0] mask);
        t_cmd hit;
        hit = CMD_NONE;
        for (int i = NUM_CMDS - 1; i >= 0; i--) begin
            if (mask[i]) begin
                hit = t_cmd'(i[2:0]);
            end
        end
        return hit;
    endfunction

endpackage

// ===== rtl/serial_command_mode_controller_top.sv =====
// Top level of the serial command mode controller: input register, event logic, result register.
// Depends on scmc_pkg for types, constants, the command table and the matching functions.
//
// Usage:
// Requests arrive on the input channel (i_in_valid / o_in_ready) as an action code with a
// byte and a sample field. Every request gives exactly one result on the output channel
// (o_out_valid / i_out_ready): a response code, the mode, the LED state and a sample echo.
// Configuration writes use a separate channel (i_cfg_valid / o_cfg_ready) with a register
// index (0 debounce ticks, 1 converter threshold) and data; it is always ready and is meant
// to be used only while no request is in flight. Other indexes are ignored.
// A request is captured in an input register, processed by combinational logic that updates
// the controller state, and its result lands in an output register, from which o_out_valid
// rises; one request is taken every cycle when the receiver keeps up. When the receiver
// stalls, the result holds and the input register can still fill; the input side then stops
// until the output register drains.
// Reset (synchronous, active low) empties both registers, returns to serial mode with an
// empty line and a dark LED, and reloads the register defaults.
module serial_command_mode_controller_top
    import scmc_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_byte_value,
    input  logic [11:0] i_sample,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_response,
    output logic [1:0]  o_mode_now,
    output logic        o_led_lit,
    output logic [11:0] o_report_value,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int LEN_W = $clog2(LINE_CAPACITY);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_CAPACITY - 1);

    logic [15:0]         r_debounce;
    logic [11:0]         r_threshold;

    logic                r_in_vld;
    t_action             r_action;
    logic [7:0]          r_byte;
    logic [11:0]         r_sample;

    t_mode               r_mode;
    logic [LEN_W-1:0]    r_len;
    logic [NUM_CMDS-1:0] r_mask;
    logic                r_ended;
    logic                r_led;
    logic                r_pending;
    logic [15:0]         r_ticks;

    logic                r_out_vld;
    t_rsp                r_rsp;
    logic [11:0]         r_report;

    t_mode               n_mode;
    logic [LEN_W-1:0]    n_len;
    logic [NUM_CMDS-1:0] n_mask;
    logic                n_ended;
    logic                n_led;
    logic                n_pending;
    logic [15:0]         n_ticks;
    t_rsp                n_rsp;
    logic [11:0]         n_report;

    logic                advance;
    logic                pos_over;
    logic [NUM_CMDS-1:0] close_mask;
    t_cmd                hit;

    assign advance     = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || advance;
    assign o_cfg_ready = 1'b1;

    assign pos_over = |(r_len >> 3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce  <= DEBOUNCE_RESET;
            r_threshold <= THRESHOLD_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE:  r_debounce  <= i_cfg_data;
                CFG_THRESHOLD: r_threshold <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_action <= t_action'(i_action);
            r_byte   <= i_byte_value;
            r_sample <= i_sample;
        end
    end

    always_comb begin
        n_mode    = r_mode;
        n_len     = r_len;
        n_mask    = r_mask;
        n_ended   = r_ended;
        n_led     = r_led;
        n_pending = r_pending;
        n_ticks   = r_ticks;
        n_rsp     = RSP_NONE;
        n_report  = '0;

        close_mask = r_ended ? r_mask : narrow_mask(r_mask, pos_over, r_len[2:0], CHAR_NUL);
        hit        = first_hit(close_mask);

        case (r_action)
            ACT_BYTE: begin
                if (r_byte == CHAR_LF || r_byte == CHAR_CR) begin
                    if (r_len != '0) begin
                        if (hit == CMD_NONE) begin
                            n_rsp = RSP_UNKNOWN;
                        end else if ((hit == CMD_LAMP_ON || hit == CMD_LAMP_OFF)
                                     && r_mode != MODE_SERIAL) begin
                            n_rsp = RSP_DENIED;
                        end else begin
                            case (hit)
                                CMD_UART: begin
                                    n_mode = MODE_SERIAL;
                                    n_rsp  = RSP_UART;
                                end
                                CMD_BUTTON: begin
                                    n_mode = MODE_PRESS;
                                    n_rsp  = RSP_BUTTON;
                                end
                                CMD_ADC: begin
                                    n_mode = MODE_CONV;
                                    n_rsp  = RSP_ADC;
                                end
                                CMD_LAMP_ON: begin
                                    n_led = 1'b1;
                                    n_rsp = RSP_LEDON;
                                end
                                default: begin
                                    n_led = 1'b0;
                                    n_rsp = RSP_LEDOFF;
                                end
                            endcase
                        end
                    end
                    n_len   = '0;
                    n_mask  = ALL_CANDIDATES;
                    n_ended = 1'b0;
                end else if (r_len < LEN_MAX) begin
                    if (!r_ended) begin
                        n_mask = narrow_mask(r_mask, pos_over, r_len[2:0], r_byte);
                        if (r_byte == CHAR_NUL) begin
                            n_ended = 1'b1;
                        end
                    end
                    n_len = r_len + LEN_W'(1);
                end
            end
            ACT_PRESS: begin
                if (r_ticks > r_debounce) begin
                    n_pending = 1'b1;
                    n_ticks   = '0;
                end
            end
            ACT_SAMPLE: begin
                if (r_mode == MODE_CONV) begin
                    n_led    = (r_sample >= r_threshold);
                    n_rsp    = RSP_REPORT;
                    n_report = r_sample;
                end
            end
            default: begin
                if (r_ticks != TICKS_MAX) begin
                    n_ticks = r_ticks + 16'd1;
                end
            end
        endcase

        // A pending press is consumed at the end of the first step that sees button mode.
        if (n_mode == MODE_PRESS && n_pending) begin
            n_pending = 1'b0;
            n_led     = !n_led;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_SERIAL;
            r_len     <= '0;
            r_mask    <= ALL_CANDIDATES;
            r_ended   <= 1'b0;
            r_led     <= 1'b0;
            r_pending <= 1'b0;
            r_ticks   <= '0;
        end else if (advance) begin
            r_mode    <= n_mode;
            r_len     <= n_len;
            r_mask    <= n_mask;
            r_ended   <= n_ended;
            r_led     <= n_led;
            r_pending <= n_pending;
            r_ticks   <= n_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_rsp    <= n_rsp;
            r_report <= n_report;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_response     = r_rsp;
    assign o_mode_now     = r_mode;
    assign o_led_lit      = r_led;
    assign o_report_value = r_report;

    a_report_only_on_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_rsp != RSP_REPORT) |-> (r_report == '0))
        else $error("report value set without a sample report");

    a_len_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_MAX)
        else $error("line length beyond capacity");

    a_no_pending_in_button_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_mode == MODE_PRESS && r_pending))
        else $error("press left pending in button mode");

    a_state_holds_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_out_ready) |=> ($stable(r_mode) && $stable(r_led)))
        else $error("controller state moved while the result was stalled");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the serial command mode controller: directed power-on, command,
// long line and debounce tests, then random traffic with and without stalls on both channels.
// Depends on scmc_pkg and serial_command_mode_controller_top from the RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import scmc_pkg::*;

    localparam int LINE_CAP        = 32;
    localparam int SETTLE_CYCLES   = 6;
    localparam int CYCLE_LIMIT     = 600000;
    localparam logic [7:0] SPARE_REG_INDEX = 8'hA5;

    typedef logic [7:0] t_byte_q[$];

    typedef struct packed {
        logic [3:0]  response;
        logic [1:0]  mode;
        logic        led;
        logic [11:0] report;
    } t_ctl_result;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [1:0]  i_action       = ACT_BYTE;
    logic [7:0]  i_byte_value   = 8'h00;
    logic [11:0] i_sample       = 12'h000;
    logic        i_out_ready    = 1'b0;
    logic        i_cfg_valid    = 1'b0;
    logic [7:0]  i_cfg_index    = 8'h00;
    logic [15:0] i_cfg_data     = 16'h0000;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [3:0]  o_response;
    logic [1:0]  o_mode_now;
    logic        o_led_lit;
    logic [11:0] o_report_value;
    logic        o_cfg_ready;

    t_ctl_result expected_results[$];
    bit          steady = 1'b0;
    int          errors = 0;
    int          items_sent = 0;
    int          results_checked = 0;
    int          lines_matched = 0;
    int          presses_taken = 0;
    int          cycles = 0;

    t_mode       ctl_mode;
    int          line_len;
    logic [4:0]  cand_mask;
    bit          text_done;
    bit          led_on;
    bit          press_waiting;
    logic [15:0] tick_count;
    logic [15:0] debounce_limit;
    logic [11:0] light_threshold;

    serial_command_mode_controller_top #(
        .LINE_CAPACITY(LINE_CAP)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_byte_value   (i_byte_value),
        .i_sample       (i_sample),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_response     (o_response),
        .o_mode_now     (o_mode_now),
        .o_led_lit      (o_led_lit),
        .o_report_value (o_report_value),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t ns: no progress, run stopped at the cycle limit", $time);
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_ready = steady || ($urandom_range(99) >= 30);
    end

    function automatic string cmd_word(t_cmd c);
        case (c)
            CMD_UART:     return "UART";
            CMD_BUTTON:   return "BUTTON";
            CMD_ADC:      return "ADC";
            CMD_LAMP_ON:  return "LEDON";
            CMD_LAMP_OFF: return "LEDOFF";
            default:      return "";
        endcase
    endfunction

    function automatic logic [7:0] name_char(t_cmd c, int pos);
        string w;
        w = cmd_word(c);
        return (pos < w.len()) ? w[pos] : CHAR_NUL;
    endfunction

    function automatic void keep_candidates(int pos, logic [7:0] b);
        for (int i = 0; i < NUM_CMDS; i++) begin
            if (name_char(t_cmd'(i), pos) != b) begin
                cand_mask[i] = 1'b0;
            end
        end
    endfunction

    function automatic t_rsp finish_line();
        t_rsp rsp;
        int   hit;
        rsp = RSP_NONE;
        hit = NUM_CMDS;
        if (line_len > 0) begin
            if (!text_done) begin
                keep_candidates(line_len, CHAR_NUL);
            end
            for (int i = NUM_CMDS - 1; i >= 0; i--) begin
                if (cand_mask[i]) begin
                    hit = i;
                end
            end
            if (hit == NUM_CMDS) begin
                rsp = RSP_UNKNOWN;
            end else if ((t_cmd'(hit) == CMD_LAMP_ON || t_cmd'(hit) == CMD_LAMP_OFF)
                         && ctl_mode != MODE_SERIAL) begin
                rsp = RSP_DENIED;
            end else begin
                lines_matched++;
                case (t_cmd'(hit))
                    CMD_UART: begin
                        ctl_mode = MODE_SERIAL;
                        rsp = RSP_UART;
                    end
                    CMD_BUTTON: begin
                        ctl_mode = MODE_PRESS;
                        rsp = RSP_BUTTON;
                    end
                    CMD_ADC: begin
                        ctl_mode = MODE_CONV;
                        rsp = RSP_ADC;
                    end
                    CMD_LAMP_ON: begin
                        led_on = 1'b1;
                        rsp = RSP_LEDON;
                    end
                    default: begin
                        led_on = 1'b0;
                        rsp = RSP_LEDOFF;
                    end
                endcase
            end
        end
        line_len = 0;
        cand_mask = ALL_CANDIDATES;
        text_done = 1'b0;
        return rsp;
    endfunction

    function automatic void controller_reset();
        debounce_limit = DEBOUNCE_RESET;
        light_threshold = THRESHOLD_RESET;
        ctl_mode = MODE_SERIAL;
        line_len = 0;
        cand_mask = ALL_CANDIDATES;
        text_done = 1'b0;
        led_on = 1'b0;
        press_waiting = 1'b0;
        tick_count = '0;
    endfunction

    function automatic t_ctl_result predict_result(t_action act, logic [7:0] b,
                                                   logic [11:0] smp);
        t_ctl_result r;
        r = '0;
        r.response = RSP_NONE;
        case (act)
            ACT_BYTE: begin
                if (b == CHAR_LF || b == CHAR_CR) begin
                    r.response = finish_line();
                end else if (line_len < LINE_CAP - 1) begin
                    if (!text_done) begin
                        keep_candidates(line_len, b);
                        if (b == CHAR_NUL) begin
                            text_done = 1'b1;
                        end
                    end
                    line_len++;
                end
            end
            ACT_PRESS: begin
                if (tick_count > debounce_limit) begin
                    press_waiting = 1'b1;
                    tick_count = '0;
                    presses_taken++;
                end
            end
            ACT_SAMPLE: begin
                if (ctl_mode == MODE_CONV) begin
                    led_on = (smp >= light_threshold);
                    r.response = RSP_REPORT;
                    r.report = smp;
                end
            end
            default: begin
                if (tick_count != TICKS_MAX) begin
                    tick_count++;
                end
            end
        endcase
        if (ctl_mode == MODE_PRESS && press_waiting) begin
            press_waiting = 1'b0;
            led_on = !led_on;
        end
        r.mode = ctl_mode;
        r.led = led_on;
        return r;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_ctl_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, got response %0d",
                         $time, o_response);
                errors++;
            end else begin
                want = expected_results.pop_front();
                check_field("response", want.response, o_response);
                check_field("mode_now", want.mode, o_mode_now);
                check_field("led_lit", want.led, o_led_lit);
                check_field("report_value", want.report, o_report_value);
                results_checked++;
            end
        end
    end

    task automatic send_item(t_action act, logic [7:0] b, logic [11:0] smp);
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < 30) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_action = act;
        i_byte_value = b;
        i_sample = smp;
        do @(posedge i_clk); while (!o_in_ready);
        expected_results.push_back(predict_result(act, b, smp));
        items_sent++;
    endtask

    task automatic send_bytes(t_byte_q q);
        foreach (q[i]) begin
            send_item(ACT_BYTE, q[i], 12'($urandom));
        end
    endtask

    function automatic t_byte_q text_bytes(string s);
        t_byte_q q;
        for (int i = 0; i < s.len(); i++) begin
            q.push_back(s[i]);
        end
        return q;
    endfunction

    task automatic send_line(string s, logic [7:0] term);
        t_byte_q q;
        q = text_bytes(s);
        q.push_back(term);
        send_bytes(q);
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_item(ACT_TICK, 8'($urandom), 12'($urandom));
    endtask

    function automatic logic [7:0] safe_byte();
        logic [7:0] v;
        v = 8'($urandom);
        if (v == CHAR_CR || v == CHAR_LF) begin
            v = 8'hFF;
        end
        return v;
    endfunction

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_DEBOUNCE) begin
            debounce_limit = data;
        end else if (idx == CFG_THRESHOLD) begin
            light_threshold = data[11:0];
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [11:0] pick_sample();
        int v;
        case ($urandom_range(3))
            0: v = $urandom_range(1) ? 4095 : 0;
            1: begin
                v = int'(light_threshold) + int'($urandom_range(2)) - 1;
                if (v < 0) v = 0;
                if (v > 4095) v = 4095;
            end
            default: v = $urandom_range(4095);
        endcase
        return v[11:0];
    endfunction

    task automatic send_random_line();
        t_byte_q q;
        int      p;
        q = text_bytes(cmd_word(t_cmd'($urandom_range(4))));
        case ($urandom_range(9))
            0: void'(q.pop_back());
            1: q.push_back(8'($urandom_range(8'h41, 8'h5A)));
            2: begin
                p = $urandom_range(q.size() - 1);
                q[p] = safe_byte();
            end
            3: begin
                q.push_back(CHAR_NUL);
                repeat ($urandom_range(3)) q.push_back(safe_byte());
            end
            default: ;
        endcase
        q.push_back($urandom_range(1) ? CHAR_CR : CHAR_LF);
        if ($urandom_range(9) == 0) begin
            q.push_back(CHAR_LF);
        end
        send_bytes(q);
    endtask

    task automatic random_traffic(int count);
        int      start;
        int      pick;
        t_byte_q q;
        start = items_sent;
        while (items_sent - start < count) begin
            pick = $urandom_range(99);
            q.delete();
            if (pick < 40) begin
                send_random_line();
            end else if (pick < 55) begin
                send_ticks($urandom_range(1, 8));
            end else if (pick < 67) begin
                send_item(ACT_PRESS, 8'($urandom), 12'($urandom));
            end else if (pick < 82) begin
                send_item(ACT_SAMPLE, 8'($urandom), pick_sample());
            end else if (pick < 95) begin
                repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(255)));
                q.push_back(CHAR_LF);
                send_bytes(q);
            end else begin
                repeat ($urandom_range(28, 40)) q.push_back(safe_byte());
                q.push_back(CHAR_CR);
                send_bytes(q);
            end
        end
    endtask

    task automatic test_power_on_state();
        send_item(ACT_PRESS, 8'h00, 12'h000);
        send_item(ACT_SAMPLE, 8'hFF, 12'hFFF);
        send_item(ACT_BYTE, CHAR_CR, 12'h000);
        send_item(ACT_BYTE, 8'hFF, 12'hFFF);
        send_item(ACT_BYTE, CHAR_LF, 12'h000);
        send_item(ACT_TICK, 8'h00, 12'h000);
        wait_idle();
    endtask

    task automatic test_command_set();
        t_byte_q q;
        send_line("LEDON", CHAR_CR);
        send_line("LEDOFF", CHAR_LF);
        send_line("ADC", CHAR_CR);
        send_item(ACT_SAMPLE, 8'h00, 12'd2047);
        send_item(ACT_SAMPLE, 8'h00, 12'd2048);
        send_item(ACT_SAMPLE, 8'h00, 12'd0);
        send_line("LEDON", CHAR_LF);
        send_line("LEDOFF", CHAR_CR);
        send_line("UAR", CHAR_CR);
        send_line("UARTX", CHAR_LF);
        send_line("UART", CHAR_LF);
        q = text_bytes("UART");
        q.push_back(CHAR_NUL);
        q.push_back("Z");
        q.push_back(CHAR_CR);
        send_bytes(q);
        q = '{CHAR_NUL, CHAR_LF};
        send_bytes(q);
        wait_idle();
    endtask

    task automatic test_long_lines();
        t_byte_q q;
        q = text_bytes("LEDON");
        q.push_back(CHAR_NUL);
        repeat (35) q.push_back(safe_byte());
        q.push_back(CHAR_LF);
        send_bytes(q);
        q = text_bytes("LEDOF");
        repeat (26) q.push_back(CHAR_NUL);
        q.push_back("F");
        q.push_back(CHAR_CR);
        send_bytes(q);
        q.delete();
        repeat (40) q.push_back("A");
        q.push_back(CHAR_CR);
        send_bytes(q);
        wait_idle();
    endtask

    task automatic test_pending_press();
        write_reg(CFG_DEBOUNCE, 16'd2);
        send_ticks(3);
        send_item(ACT_PRESS, 8'h00, 12'h000);
        send_item(ACT_SAMPLE, 8'h00, 12'hFFF);
        send_line("BUTTON", CHAR_CR);
        send_item(ACT_PRESS, 8'h00, 12'h000);
        send_ticks(3);
        send_item(ACT_PRESS, 8'h00, 12'h000);
        send_line("ADC", CHAR_LF);
        send_ticks(3);
        send_item(ACT_PRESS, 8'h00, 12'h000);
        send_line("LEDON", CHAR_LF);
        send_line("UART", CHAR_CR);
        send_line("BUTTON", CHAR_LF);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        write_reg(CFG_DEBOUNCE, 16'd0);
        write_reg(CFG_THRESHOLD, 16'd0);
        random_traffic(150);
        wait_idle();
        write_reg(CFG_DEBOUNCE, 16'd65535);
        write_reg(CFG_THRESHOLD, 16'd4095);
        write_reg(SPARE_REG_INDEX, 16'($urandom));
        random_traffic(100);
        wait_idle();
        write_reg(CFG_DEBOUNCE, 16'd3);
        write_reg(CFG_THRESHOLD, 16'($urandom));
        steady = 1'b1;
        random_traffic(200);
        steady = 1'b0;
        wait_idle();
        write_reg(CFG_DEBOUNCE, 16'($urandom_range(12)));
        write_reg(CFG_THRESHOLD, 16'($urandom_range(4095)));
        random_traffic(250);
        wait_idle();
    endtask

    initial begin
        controller_reset();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_power_on_state();
        test_command_set();
        test_long_lines();
        test_pending_press();
        test_random_traffic();
        wait_idle();
        $display("Covered %0d requests with %0d results checked: %0d lines matched a command,",
                 items_sent, results_checked, lines_matched);
        $display("%0d presses passed the debounce, mismatches found: %0d", presses_taken, errors);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/scmc_pkg.sv
rtl/serial_command_mode_controller_top.sv
tb/sv/testbench.sv
